// ----- design/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants for the sensor report trigger
// Command and cause codes, register indexes, reset values and the band rule.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int unsigned ValW   = 10;
  localparam int unsigned TickW  = 16;
  localparam int unsigned TrigW  = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW   = 16;

  typedef enum logic [1:0] {
    CmdSample = 2'd0,
    CmdTick   = 2'd1,
    CmdStart  = 2'd2,
    CmdStop   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CauseNow   = 2'd0,
    CauseQuiet = 2'd1,
    CauseMax   = 2'd2,
    CauseStart = 2'd3
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegLowLimit  = 3'd0,
    RegHighLimit = 3'd1,
    RegStepSize  = 3'd2,
    RegMinPeriod = 3'd3,
    RegMaxPeriod = 3'd4
  } cfg_reg_e;

  localparam logic [1:0] BandLow  = 2'd0;
  localparam logic [1:0] BandMid  = 2'd1;
  localparam logic [1:0] BandHigh = 2'd2;

  localparam logic [ValW-1:0]  LowLimitRst  = 10'd250;
  localparam logic [ValW-1:0]  HighLimitRst = 10'd750;
  localparam logic [ValW-1:0]  StepSizeRst  = 10'd10;
  localparam logic [TickW-1:0] MinPeriodRst = 16'd10;
  localparam logic [TickW-1:0] MaxPeriodRst = 16'd600;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  function automatic logic [1:0] band_of(input logic [ValW-1:0] v,
                                         input logic [ValW-1:0] lo,
                                         input logic [ValW-1:0] hi);
    logic [1:0] b;
    if (v > hi) begin
      b = BandHigh;
    end else if (v <= lo) begin
      b = BandLow;
    end else begin
      b = BandMid;
    end
    return b;
  endfunction

endpackage

// ----- design/sensor_report_trigger_top.sv -----
// ----------------------------------------------------------------------------
// sensor_report_trigger_top: decides when a sensor value is reported
// Band, step, quiet period and timeout rules on a stream of sample, tick,
// start and stop items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries command_i and
//   sample_value_i. An item is taken on a clock edge with valid high and
//   stall low. Each item lands in an input register; the decision logic
//   then updates the tracking state and, if a report is due, loads the
//   result register (out_valid_o / out_stall_i).
//   Throughput: 1 item per cycle; the only limit is the single result
//   register. Items that give no report pass even while a result waits.
//   An item that gives a report waits in the input register while the
//   receiver stalls a previous report; then in_stall_o goes high.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) must be written only
//   while the block is idle; the block does not enforce this. A write takes
//   effect at once; unknown indexes are ignored. Reset: registers return to
//   their defaults, state clears, nothing is observed until a start item.
// ----------------------------------------------------------------------------
module sensor_report_trigger_top
  import srt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [ValW-1:0]     sample_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ValW-1:0]     reported_value_o,
  output logic [1:0]          reported_band_o,
  output logic [1:0]          cause_o
);

  // configuration
  logic [ValW-1:0]  low_limit_q, high_limit_q, step_size_q;
  logic [TickW-1:0] min_period_q, max_period_q;

  // input register
  logic            in_valid_q;
  cmd_e            cmd_q;
  logic [ValW-1:0] sample_q;

  // tracking state
  logic [ValW-1:0]         latest_q, latest_d;
  logic [ValW-1:0]         prev_q, prev_d;
  logic [1:0]              band_q, band_d;
  logic signed [TrigW-1:0] upper_q, upper_d, lower_q, lower_d;
  logic [TickW-1:0]        quiet_cnt_q, quiet_cnt_d, tmo_cnt_q, tmo_cnt_d;
  logic                    quiet_over_q, quiet_over_d;
  logic                    pending_q, pending_d;
  logic                    observing_q, observing_d;

  // result register
  logic            out_valid_q;
  logic [ValW-1:0] out_value_q;
  logic [1:0]      out_band_q;
  cause_e          out_cause_q;

  // decision
  logic                    emit;
  logic [ValW-1:0]         emit_val;
  cause_e                  emit_cause;
  logic [1:0]              emit_band;
  logic                    out_free, advance, out_load;
  logic signed [TrigW-1:0] s_ext;
  logic [TickW-1:0]        quiet_inc, tmo_inc;

  always_comb begin
    latest_d     = latest_q;
    prev_d       = prev_q;
    band_d       = band_q;
    upper_d      = upper_q;
    lower_d      = lower_q;
    quiet_cnt_d  = quiet_cnt_q;
    tmo_cnt_d    = tmo_cnt_q;
    quiet_over_d = quiet_over_q;
    pending_d    = pending_q;
    observing_d  = observing_q;
    emit         = 1'b0;
    emit_val     = latest_q;
    emit_cause   = CauseNow;
    s_ext        = $signed({{(TrigW-ValW){1'b0}}, sample_q});
    quiet_inc    = (quiet_cnt_q < TickMax) ? quiet_cnt_q + 1'b1 : quiet_cnt_q;
    tmo_inc      = (tmo_cnt_q < TickMax) ? tmo_cnt_q + 1'b1 : tmo_cnt_q;

    case (cmd_q)
      CmdSample: begin
        latest_d = sample_q;
        if (observing_q && (sample_q != prev_q)) begin
          prev_d = sample_q;
          if ((band_of(sample_q, low_limit_q, high_limit_q) != band_q) ||
              (s_ext >= upper_q) || (s_ext <= lower_q)) begin
            if (quiet_over_q) begin
              emit     = 1'b1;
              emit_val = sample_q;
            end else begin
              pending_d = 1'b1;
            end
          end
        end
      end
      CmdTick: begin
        if (observing_q) begin
          // quiet period is resolved before the timeout on the same tick
          if (!quiet_over_q) begin
            quiet_cnt_d = quiet_inc;
            if (quiet_inc >= min_period_q) begin
              if (pending_q) begin
                pending_d  = 1'b0;
                emit       = 1'b1;
                emit_cause = CauseQuiet;
              end else begin
                quiet_over_d = 1'b1;
              end
            end
          end
          if (!emit) begin
            tmo_cnt_d = tmo_inc;
            if (tmo_inc >= max_period_q) begin
              emit       = 1'b1;
              emit_cause = CauseMax;
            end
          end
        end
      end
      CmdStart: begin
        observing_d = 1'b1;
        emit        = 1'b1;
        emit_cause  = CauseStart;
      end
      default: begin
        observing_d = 1'b0;
        pending_d   = 1'b0;
      end
    endcase

    emit_band = band_of(emit_val, low_limit_q, high_limit_q);
    if (emit) begin
      band_d       = emit_band;
      upper_d      = $signed({{(TrigW-ValW){1'b0}}, emit_val}) +
                     $signed({{(TrigW-ValW){1'b0}}, step_size_q});
      lower_d      = $signed({{(TrigW-ValW){1'b0}}, emit_val}) -
                     $signed({{(TrigW-ValW){1'b0}}, step_size_q});
      quiet_cnt_d  = '0;
      quiet_over_d = (min_period_q == '0);
      tmo_cnt_d    = '0;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign out_load   = advance && emit;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LowLimitRst;
      high_limit_q <= HighLimitRst;
      step_size_q  <= StepSizeRst;
      min_period_q <= MinPeriodRst;
      max_period_q <= MaxPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLowLimit:  low_limit_q  <= cfg_data_i[ValW-1:0];
        RegHighLimit: high_limit_q <= cfg_data_i[ValW-1:0];
        RegStepSize:  step_size_q  <= cfg_data_i[ValW-1:0];
        RegMinPeriod: min_period_q <= cfg_data_i[TickW-1:0];
        RegMaxPeriod: max_period_q <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q    <= cmd_e'(command_i);
      sample_q <= sample_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q     <= '0;
      prev_q       <= '0;
      band_q       <= '0;
      upper_q      <= '0;
      lower_q      <= '0;
      quiet_cnt_q  <= '0;
      tmo_cnt_q    <= '0;
      quiet_over_q <= 1'b0;
      pending_q    <= 1'b0;
      observing_q  <= 1'b0;
    end else if (advance) begin
      latest_q     <= latest_d;
      prev_q       <= prev_d;
      band_q       <= band_d;
      upper_q      <= upper_d;
      lower_q      <= lower_d;
      quiet_cnt_q  <= quiet_cnt_d;
      tmo_cnt_q    <= tmo_cnt_d;
      quiet_over_q <= quiet_over_d;
      pending_q    <= pending_d;
      observing_q  <= observing_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= emit_val;
      out_band_q  <= emit_band;
      out_cause_q <= emit_cause;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reported_value_o = out_value_q;
  assign reported_band_o  = out_band_q;
  assign cause_o          = out_cause_q;

  // a report restarts both periods
  a_report_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (quiet_cnt_q == '0) && (tmo_cnt_q == '0))
    else $error("periods not restarted after report");

  // nothing is held back while not observing
  a_pending_needs_obs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !observing_q |-> !pending_q)
    else $error("held-back report while not observing");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result register overwritten while stalled");

  // a reported band is never the unused code
  a_band_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_band_q != 2'd3))
    else $error("illegal band in report");

endmodule

// ----- verif/sensor_report_trigger_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_report_trigger_top_tb: self-checking bench for the report trigger
// Drives sample, tick, start and stop items with random gaps, stalls the
// report side at random, tracks band, step, quiet period and timeout state
// in a local tracker and checks every report field against it, in order.
// ----------------------------------------------------------------------------
module sensor_report_trigger_top_tb;
  import srt_pkg::*;

  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit    = 3_000_000;
  localparam int unsigned RandomPhases  = 7;
  localparam int unsigned PhaseItems    = 220;
  localparam int unsigned LongTicks     = 160;
  localparam logic [TickW-1:0] LongMaxPeriod = 16'd150;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [1:0]      band;
    cause_e          cause;
  } report_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         command_i;
  logic [ValW-1:0]    sample_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ValW-1:0]    reported_value_o;
  logic [1:0]         reported_band_o;
  logic [1:0]         cause_o;

  // register shadow
  logic [ValW-1:0]  lo_lim, hi_lim, step_amt;
  logic [TickW-1:0] pmin_ticks, pmax_ticks;

  // tracker state
  logic [ValW-1:0]         latest, prev_seen;
  logic [1:0]              rep_band;
  logic signed [TrigW-1:0] up_trig, lo_trig;
  logic [TickW-1:0]        quiet_cnt, tmo_cnt;
  bit                      quiet_done, held, observing;

  report_t expected_reports[$];

  logic [ValW-1:0] walk_val = '0;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned reports_by_cause[4];

  sensor_report_trigger_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .sample_value_i   (sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reported_value_o (reported_value_o),
    .reported_band_o  (reported_band_o),
    .cause_o          (cause_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               expected_reports.size());
      $display("** sensor_report_trigger_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tracker

  function automatic logic [1:0] band_for(input logic [ValW-1:0] v);
    if (v > hi_lim) begin
      return BandHigh;
    end else if (v <= lo_lim) begin
      return BandLow;
    end
    return BandMid;
  endfunction

  function automatic void issue_report(input logic [ValW-1:0] v, input cause_e why);
    report_t r;
    rep_band   = band_for(v);
    up_trig    = $signed({2'b00, v}) + $signed({2'b00, step_amt});
    lo_trig    = $signed({2'b00, v}) - $signed({2'b00, step_amt});
    quiet_cnt  = '0;
    quiet_done = (pmin_ticks == '0);
    tmo_cnt    = '0;
    r.value    = v;
    r.band     = rep_band;
    r.cause    = why;
    expected_reports.push_back(r);
  endfunction

  function automatic void track_item(input cmd_e cmd, input logic [ValW-1:0] s);
    bit                      fired;
    logic signed [TrigW-1:0] sv;
    fired = 1'b0;
    sv    = $signed({2'b00, s});
    case (cmd)
      CmdSample: begin
        latest = s;
        if (observing && s != prev_seen) begin
          prev_seen = s;
          if (band_for(s) != rep_band || sv >= up_trig || sv <= lo_trig) begin
            if (quiet_done) begin
              issue_report(s, CauseNow);
            end else begin
              held = 1'b1;
            end
          end
        end
      end
      CmdTick: begin
        if (observing) begin
          // quiet period is settled first; its report restarts the timeout
          if (!quiet_done) begin
            if (quiet_cnt != TickMax) quiet_cnt++;
            if (quiet_cnt >= pmin_ticks) begin
              if (held) begin
                held = 1'b0;
                issue_report(latest, CauseQuiet);
                fired = 1'b1;
              end else begin
                quiet_done = 1'b1;
              end
            end
          end
          if (!fired) begin
            if (tmo_cnt != TickMax) tmo_cnt++;
            if (tmo_cnt >= pmax_ticks) issue_report(latest, CauseMax);
          end
        end
      end
      CmdStart: begin
        observing = 1'b1;
        issue_report(latest, CauseStart);
      end
      default: begin
        observing = 1'b0;
        held      = 1'b0;
      end
    endcase
  endfunction

  function automatic void reset_tracker();
    lo_lim     = LowLimitRst;
    hi_lim     = HighLimitRst;
    step_amt   = StepSizeRst;
    pmin_ticks = MinPeriodRst;
    pmax_ticks = MaxPeriodRst;
    latest     = '0;
    prev_seen  = '0;
    rep_band   = BandLow;
    up_trig    = '0;
    lo_trig    = '0;
    quiet_cnt  = '0;
    tmo_cnt    = '0;
    quiet_done = 1'b0;
    held       = 1'b0;
    observing  = 1'b0;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int unsigned idle_len(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    return ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a back-to-back item needs no second assignment.
  task automatic send_item(input cmd_e cmd, input logic [ValW-1:0] val);
    int unsigned gap;
    gap = idle_len(gap_pct);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    sample_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    track_item(cmd, val);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected report, then let the input and
  // decision registers empty out.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLowLimit:  lo_lim     = data[ValW-1:0];
      RegHighLimit: hi_lim     = data[ValW-1:0];
      RegStepSize:  step_amt   = data[ValW-1:0];
      RegMinPeriod: pmin_ticks = data;
      RegMaxPeriod: pmax_ticks = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic configure(input logic [ValW-1:0] lo, input logic [ValW-1:0] hi,
                           input logic [ValW-1:0] step,
                           input logic [TickW-1:0] pmin, input logic [TickW-1:0] pmax);
    write_reg(RegLowLimit, CfgW'(lo));
    write_reg(RegHighLimit, CfgW'(hi));
    write_reg(RegStepSize, CfgW'(step));
    write_reg(RegMinPeriod, pmin);
    write_reg(RegMaxPeriod, pmax);
  endtask

  // Mostly a walk around the last value and the band edges, with jumps,
  // repeats and readings near both ends of the range.
  function automatic logic [ValW-1:0] pick_sample();
    int          v;
    int          span;
    int unsigned r;
    r    = $urandom_range(99);
    span = int'(step_amt) + 4;
    if (r < 45) begin
      v = int'(walk_val) + int'($urandom_range(0, 2 * span)) - span;
    end else if (r < 65) begin
      v = ($urandom_range(1) ? int'(lo_lim) : int'(hi_lim)) + int'($urandom_range(0, 4)) - 2;
    end else if (r < 75) begin
      v = int'(walk_val);
    end else if (r < 85) begin
      v = $urandom_range(1) ? 1023 - int'($urandom_range(0, 23)) : int'($urandom_range(0, 3));
    end else begin
      v = int'($urandom_range(0, 1023));
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    walk_val = v[ValW-1:0];
    return walk_val;
  endfunction

  // report side: random stalls, or one long hold-off on request
  initial begin : result_side
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        n = idle_len(stall_pct);
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_reports
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("report value %0d band %0d cause %0d with none expected",
                                reported_value_o, reported_band_o, cause_o));
      end else begin
        want = expected_reports.pop_front();
        reports_by_cause[want.cause]++;
        if (reported_value_o !== want.value)
          note_mismatch($sformatf("value %0d, expected %0d", reported_value_o, want.value));
        if (reported_band_o !== want.band)
          note_mismatch($sformatf("band %0d, expected %0d", reported_band_o, want.band));
        if (cause_o !== want.cause)
          note_mismatch($sformatf("cause %0d, expected %0d", cause_o, want.cause));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_defaults();
    gap_pct   = 0;
    stall_pct = 0;
    send_item(CmdSample, 10'd1023);   // not observing: only latched
    send_item(CmdTick, 10'd0);        // ignored while not observing
    send_item(CmdStart, 10'd0);
    send_item(CmdSample, 10'd1013);   // exactly at the lower trigger, held in quiet period
    send_item(CmdStop, 10'd0);        // drops the held report
    send_item(CmdStart, 10'd0);
    send_item(CmdSample, 10'd0);
    send_item(CmdStart, 10'd0);       // start while already observing
  endtask

  task automatic test_special_cases();
    // inverted limits, zero step, zero quiet period, zero timeout
    configure(10'd900, 10'd100, 10'd0, 16'd0, 16'd0);
    send_item(CmdStart, 10'd0);
    send_item(CmdSample, 10'd500);
    send_item(CmdSample, 10'd501);
    send_item(CmdSample, 10'd501);
    send_item(CmdTick, 10'd0);
    send_item(CmdStop, 10'd0);
    send_item(CmdTick, 10'd0);
    // quiet period and timeout expire on the same tick
    configure(LowLimitRst, HighLimitRst, 10'd5, 16'd2, 16'd2);
    send_item(CmdStart, 10'd0);
    send_item(CmdSample, 10'd600);
    repeat (4) send_item(CmdTick, 10'd0);
    // timeout fires while a report is held; it still comes at quiet end
    write_reg(RegMinPeriod, 16'd4);
    send_item(CmdSample, 10'd700);
    repeat (2) send_item(CmdTick, 10'd0);
    write_reg(RegMaxPeriod, 16'd100);
    repeat (4) send_item(CmdTick, 10'd0);
  endtask

  task automatic test_long_periods();
    // quiet period never ends; the timeout fires with a report still held
    configure(LowLimitRst, HighLimitRst, StepSizeRst, TickMax, LongMaxPeriod);
    gap_pct   = 0;
    stall_pct = 0;
    send_item(CmdStart, 10'd0);
    send_item(CmdSample, 10'd0);
    send_item(CmdSample, 10'd1000);
    repeat (LongTicks) send_item(CmdTick, 10'd0);
  endtask

  task automatic test_backpressure();
    logic [ValW-1:0] v;
    configure(LowLimitRst, HighLimitRst, 10'd0, 16'd0, TickMax);
    gap_pct      = 0;
    stall_pct    = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) begin
        send_item(CmdStart, 10'd0);
      end else begin
        v = pick_sample();
        send_item(CmdSample, v);
      end
    end
  endtask

  task automatic test_random_phases();
    int unsigned     r;
    logic [ValW-1:0] lo, hi, step, noise;
    logic [TickW-1:0] pmin, pmax;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) begin
        configure(10'd0, 10'd0, 10'd0, 16'd0, 16'd1);
      end else if (phase == 1) begin
        configure(10'd1000, 10'd1000, 10'd1000, TickMax, TickMax);
      end else begin
        lo   = ValW'($urandom_range(0, 1000));
        hi   = ValW'($urandom_range(0, 1000));
        step = ($urandom_range(3) == 0) ? ValW'($urandom_range(0, 1023)) :
                                          ValW'($urandom_range(0, 30));
        pmin = TickW'($urandom_range(0, 12));
        pmax = ($urandom_range(5) == 0) ? 16'd0 : TickW'($urandom_range(1, 40));
        configure(lo, hi, step, pmin, pmax);
      end
      // phase 2 runs without any idling
      gap_pct   = (phase == 2) ? 0 : $urandom_range(0, 3) * 20;
      stall_pct = (phase == 2) ? 0 : $urandom_range(0, 3) * 20;
      send_item(CmdStart, 10'd0);
      for (int i = 0; i < PhaseItems; i++) begin
        r     = $urandom_range(99);
        noise = ValW'($urandom());
        if (r < 52) begin
          send_item(CmdSample, pick_sample());
        end else if (r < 90) begin
          send_item(CmdTick, noise);
        end else if (r < 93) begin
          send_item(CmdStop, noise);
        end else begin
          send_item(CmdStart, noise);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = RegLowLimit;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    command_i      = CmdSample;
    sample_value_i = '0;
    reset_tracker();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_defaults();
    test_special_cases();
    test_long_periods();
    test_backpressure();
    test_random_phases();

    settle_block();
    repeat (TailCycles) @(negedge clk_i);

    $display("run: %0d items, %0d register writes, %0d config phases plus directed cases",
             items_sent, cfg_writes, RandomPhases);
    $display("reports checked: %0d immediate, %0d deferred, %0d timeout, %0d start",
             reports_by_cause[CauseNow], reports_by_cause[CauseQuiet],
             reports_by_cause[CauseMax], reports_by_cause[CauseStart]);
    if (mismatches == 0) begin
      $display("** sensor_report_trigger_top: PASSED **");
    end else begin
      $display("** sensor_report_trigger_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/srt_pkg.sv
design/sensor_report_trigger_top.sv
verif/sensor_report_trigger_top_tb.sv
